>>> sv/jlvbs_pkg.sv
// Shared types and fixed widths for the joint-limit velocity bound shaper.
package jlvbs_pkg;

  localparam int TAG_W  = 6;
  localparam int POS_W  = 24;
  localparam int VEL_W  = 32;
  localparam int DIFF_W = POS_W + 1;
  localparam int RNG_W  = POS_W;
  localparam int SCL_W  = 32;

  localparam logic [63:0] Q30_ONE = 64'd1 << 30;

  typedef enum logic [1:0] {
    REGION_INTERIOR = 2'd0,
    REGION_LOWER    = 2'd1,
    REGION_UPPER    = 2'd2
  } region_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [VEL_W-1:0] vmin;
    logic [VEL_W-1:0] vmax;
    logic [VEL_W-1:0] vprev;
    region_t          region;
    logic             zero;
    logic             band;
  } side_t;

endpackage

>>> sv/joint_limit_velocity_bound_shaper.sv
// Joint-limit velocity bound shaper: guard-band sigmoid shaping of joint velocity limits.
//
//   channel  direction  handshake               payload
//   in_      input      in_valid / in_ready     joint_index, joint_pos, pos_min, pos_max,
//                                               vel_min, vel_max, vel_prev
//   out_     output     out_valid / out_ready   joint_tag, vel_low, vel_high, start_vel, region
//
// One joint enters per cycle unless every stage is full and the output is not taken.
// The depth is set by the band-index divider, which resolves one quotient bit per stage.
// Reset clears the stage valid bits only; payload registers load without reset.
// A stage advances whenever it or any stage downstream of it is empty or the output is taken,
// so bubbles collapse under a stall and input is taken while a result waits.
module joint_limit_velocity_bound_shaper #(
  parameter int SIGMOID_ENTRIES = 256,
  parameter int FRAC_BITS       = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic        [jlvbs_pkg::TAG_W-1:0]  in_joint_index,
  input  logic signed [jlvbs_pkg::POS_W-1:0]  in_joint_pos,
  input  logic signed [jlvbs_pkg::POS_W-1:0]  in_pos_min,
  input  logic signed [jlvbs_pkg::POS_W-1:0]  in_pos_max,
  input  logic signed [jlvbs_pkg::VEL_W-1:0]  in_vel_min,
  input  logic signed [jlvbs_pkg::VEL_W-1:0]  in_vel_max,
  input  logic signed [jlvbs_pkg::VEL_W-1:0]  in_vel_prev,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic        [jlvbs_pkg::TAG_W-1:0]  out_joint_tag,
  output logic signed [jlvbs_pkg::VEL_W-1:0]  out_vel_low,
  output logic signed [jlvbs_pkg::VEL_W-1:0]  out_vel_high,
  output logic signed [jlvbs_pkg::VEL_W-1:0]  out_start_vel,
  output logic        [1:0]                   out_region
);

  localparam int QB     = $clog2(SIGMOID_ENTRIES);
  localparam int FW     = FRAC_BITS + 1;
  localparam int NST    = QB + 6;
  localparam int S_IN   = 0;
  localparam int S_BAND = 1;
  localparam int S_PREP = 2;
  localparam int S_ROM  = QB + 3;
  localparam int S_MUL  = QB + 4;
  localparam int S_OUT  = QB + 5;
  localparam int VW     = jlvbs_pkg::VEL_W;
  localparam int RW     = jlvbs_pkg::RNG_W;
  localparam int DW     = jlvbs_pkg::DIFF_W;
  localparam int SW     = jlvbs_pkg::SCL_W;
  localparam int PW     = VW + FW;

  // ---------------------------------------------------------------- sigmoid ROM
  logic [FW-1:0] rom_tab [SIGMOID_ENTRIES];

  for (genvar gk = 0; gk < SIGMOID_ENTRIES; gk++) begin : g_rom
    localparam bit [63:0]     ONE = jlvbs_pkg::Q30_ONE;
    localparam longint signed T   = 2 * gk + 1 - SIGMOID_ENTRIES;
    localparam bit [63:0]     MAG = (T < 0) ? -T : T;
    localparam bit [63:0]     A   = ((64'd10 * MAG) << 30) / SIGMOID_ENTRIES;
    localparam bit [63:0]     Y   = A / 16;
    localparam bit [63:0] TM1  = ((ONE  * Y) >> 30) / 1;
    localparam bit [63:0] S1   = (ONE > TM1) ? ONE - TM1 : 64'd0;
    localparam bit [63:0] TM2  = ((TM1  * Y) >> 30) / 2;
    localparam bit [63:0] S2   = S1 + TM2;
    localparam bit [63:0] TM3  = ((TM2  * Y) >> 30) / 3;
    localparam bit [63:0] S3   = (S2 > TM3) ? S2 - TM3 : 64'd0;
    localparam bit [63:0] TM4  = ((TM3  * Y) >> 30) / 4;
    localparam bit [63:0] S4   = S3 + TM4;
    localparam bit [63:0] TM5  = ((TM4  * Y) >> 30) / 5;
    localparam bit [63:0] S5   = (S4 > TM5) ? S4 - TM5 : 64'd0;
    localparam bit [63:0] TM6  = ((TM5  * Y) >> 30) / 6;
    localparam bit [63:0] S6   = S5 + TM6;
    localparam bit [63:0] TM7  = ((TM6  * Y) >> 30) / 7;
    localparam bit [63:0] S7   = (S6 > TM7) ? S6 - TM7 : 64'd0;
    localparam bit [63:0] TM8  = ((TM7  * Y) >> 30) / 8;
    localparam bit [63:0] S8   = S7 + TM8;
    localparam bit [63:0] TM9  = ((TM8  * Y) >> 30) / 9;
    localparam bit [63:0] S9   = (S8 > TM9) ? S8 - TM9 : 64'd0;
    localparam bit [63:0] TM10 = ((TM9  * Y) >> 30) / 10;
    localparam bit [63:0] S10  = S9 + TM10;
    localparam bit [63:0] TM11 = ((TM10 * Y) >> 30) / 11;
    localparam bit [63:0] S11  = (S10 > TM11) ? S10 - TM11 : 64'd0;
    localparam bit [63:0] TM12 = ((TM11 * Y) >> 30) / 12;
    localparam bit [63:0] S12  = S11 + TM12;
    localparam bit [63:0] TM13 = ((TM12 * Y) >> 30) / 13;
    localparam bit [63:0] S13  = (S12 > TM13) ? S12 - TM13 : 64'd0;
    localparam bit [63:0] TM14 = ((TM13 * Y) >> 30) / 14;
    localparam bit [63:0] S14  = S13 + TM14;
    localparam bit [63:0] E1   = (S14 * S14) >> 30;
    localparam bit [63:0] E2   = (E1 * E1) >> 30;
    localparam bit [63:0] E3   = (E2 * E2) >> 30;
    localparam bit [63:0] E4   = (E3 * E3) >> 30;
    localparam bit [63:0] NUM  = (T >= 0) ? ONE : E4;
    localparam bit [63:0] DEN  = ONE + E4;
    localparam bit [63:0] FACTOR = ((NUM << FRAC_BITS) + (DEN >> 1)) / DEN;
    assign rom_tab[gk] = FW'(FACTOR);
  end

  // ---------------------------------------------------------------- flow control
  logic [NST-1:0] vld_r;
  logic [NST-1:0] vld_nxt;
  logic [NST-1:0] adv;

  for (genvar gi = 0; gi < NST; gi++) begin : g_adv
    assign adv[gi] = out_ready || !(&vld_r[NST-1:gi]);
  end

  always_comb begin
    vld_nxt[0] = adv[0] ? in_valid : vld_r[0];
    for (int i = 1; i < NST; i++) begin
      vld_nxt[i] = adv[i] ? vld_r[i-1] : vld_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = adv[S_IN];
  assign out_valid = vld_r[S_OUT];

  // ---------------------------------------------------------------- stage 0: differences
  jlvbs_pkg::side_t side_r [S_MUL+1];
  logic signed [DW-1:0] dlo_r, dhi_r, rng_r;
  logic signed [DW-1:0] dlo_nxt, dhi_nxt, rng_nxt;

  assign dlo_nxt = DW'(in_joint_pos) - DW'(in_pos_min);
  assign dhi_nxt = DW'(in_pos_max) - DW'(in_joint_pos);
  assign rng_nxt = DW'(in_pos_max) - DW'(in_pos_min);

  always_ff @(posedge clk) begin
    if (adv[S_IN]) begin
      dlo_r                <= dlo_nxt;
      dhi_r                <= dhi_nxt;
      rng_r                <= rng_nxt;
      side_r[S_IN].tag     <= in_joint_index;
      side_r[S_IN].vmin    <= in_vel_min;
      side_r[S_IN].vmax    <= in_vel_max;
      side_r[S_IN].vprev   <= in_vel_prev;
      side_r[S_IN].region  <= jlvbs_pkg::REGION_INTERIOR;
      side_r[S_IN].zero    <= 1'b0;
      side_r[S_IN].band    <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- stage 1: band tests
  logic signed [SW-1:0] lo32, hi32, rng32, lo40, hi40, rng2, dsel;
  logic                 lo_ok, hi_ok;
  jlvbs_pkg::side_t     band_side_nxt;
  logic [RW-1:0]        band_u_r, band_rng_r, band_u_nxt;

  always_comb begin
    lo32  = SW'(dlo_r);
    hi32  = SW'(dhi_r);
    rng32 = SW'(rng_r);
    // scale by 40 as 32x + 8x
    lo40  = (lo32 <<< 5) + (lo32 <<< 3);
    hi40  = (hi32 <<< 5) + (hi32 <<< 3);
    rng2  = rng32 <<< 1;
    lo_ok = lo40 >= rng2;
    hi_ok = hi40 >= rng2;
    dsel  = lo_ok ? hi40 : lo40;
    band_side_nxt = side_r[S_IN];
    if (lo_ok && hi_ok) begin
      band_side_nxt.region = jlvbs_pkg::REGION_INTERIOR;
    end else if (!lo_ok) begin
      band_side_nxt.region = jlvbs_pkg::REGION_LOWER;
    end else begin
      band_side_nxt.region = jlvbs_pkg::REGION_UPPER;
    end
    band_side_nxt.zero = !(lo_ok && hi_ok) && (dsel <= rng32);
    band_side_nxt.band = !(lo_ok && hi_ok) && (dsel > rng32);
    band_u_nxt         = RW'(dsel - rng32);
  end

  always_ff @(posedge clk) begin
    if (adv[S_BAND]) begin
      side_r[S_BAND] <= band_side_nxt;
      band_u_r       <= band_u_nxt;
      band_rng_r     <= rng_r[RW-1:0];
    end
  end

  // ---------------------------------------------------------------- stage 2: divider setup
  logic [RW-1:0]    div_rem_r [QB+1];
  logic [QB-1:0]    div_low_r [QB+1];
  logic [QB-1:0]    div_quo_r [QB+1];
  logic [RW-1:0]    div_rng_r [QB+1];
  logic [RW+QB-1:0] numer;

  // numerator u*N; its upper part is already below the divisor
  assign numer = (RW+QB)'(band_u_r) * (RW+QB)'(SIGMOID_ENTRIES);

  always_ff @(posedge clk) begin
    if (adv[S_PREP]) begin
      side_r[S_PREP] <= side_r[S_BAND];
      div_rem_r[0]   <= numer[RW+QB-1:QB];
      div_low_r[0]   <= numer[QB-1:0];
      div_quo_r[0]   <= '0;
      div_rng_r[0]   <= band_rng_r;
    end
  end

  // ---------------------------------------------------------------- divider: one bit a stage
  for (genvar gj = 0; gj < QB; gj++) begin : g_div
    logic [RW:0]   remx;
    logic          ge;
    logic [RW-1:0] rem_nxt;

    always_comb begin
      remx    = {div_rem_r[gj], div_low_r[gj][QB-1-gj]};
      ge      = remx >= {1'b0, div_rng_r[gj]};
      rem_nxt = ge ? RW'(remx - {1'b0, div_rng_r[gj]}) : remx[RW-1:0];
    end

    always_ff @(posedge clk) begin
      if (adv[S_PREP+1+gj]) begin
        side_r[S_PREP+1+gj] <= side_r[S_PREP+gj];
        div_rem_r[gj+1]     <= rem_nxt;
        div_low_r[gj+1]     <= div_low_r[gj];
        div_quo_r[gj+1]     <= QB'({div_quo_r[gj], ge});
        div_rng_r[gj+1]     <= div_rng_r[gj];
      end
    end
  end

  // ---------------------------------------------------------------- ROM lookup
  logic [QB-1:0] rom_idx;
  logic [FW-1:0] fac_r;

  assign rom_idx = ((QB+1)'(div_quo_r[QB]) >= (QB+1)'(SIGMOID_ENTRIES)) ?
                   QB'(SIGMOID_ENTRIES - 1) : div_quo_r[QB];

  always_ff @(posedge clk) begin
    if (adv[S_ROM]) begin
      side_r[S_ROM] <= side_r[S_ROM-1];
      fac_r         <= rom_tab[rom_idx];
    end
  end

  // ---------------------------------------------------------------- scale the shaped bound
  logic signed [VW-1:0] vsel, scaled, bnd_r, bnd_nxt;
  logic signed [PW-1:0] prod;

  always_comb begin
    vsel = (side_r[S_ROM].region == jlvbs_pkg::REGION_LOWER) ?
           $signed(side_r[S_ROM].vmin) : $signed(side_r[S_ROM].vmax);
    prod   = PW'(vsel) * $signed({1'b0, fac_r});
    // arithmetic shift floors toward minus infinity
    scaled = VW'(prod >>> FRAC_BITS);
    if (side_r[S_ROM].zero) begin
      bnd_nxt = '0;
    end else if (side_r[S_ROM].band) begin
      bnd_nxt = scaled;
    end else begin
      bnd_nxt = vsel;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[S_MUL]) begin
      side_r[S_MUL] <= side_r[S_ROM];
      bnd_r         <= bnd_nxt;
    end
  end

  // ---------------------------------------------------------------- reconcile and clamp
  logic signed [VW-1:0] raw_lo, raw_hi, vprev_s, xl, xu, sv_a, sv;
  logic signed [VW:0]   lo_ext, hi_ext, abs_lo, abs_hi;
  logic        [jlvbs_pkg::TAG_W-1:0] tag_r;
  logic signed [VW-1:0] vlo_r, vhi_r, sv_r;
  jlvbs_pkg::region_t   region_r;

  always_comb begin
    raw_lo  = (side_r[S_MUL].region == jlvbs_pkg::REGION_LOWER) ?
              bnd_r : $signed(side_r[S_MUL].vmin);
    raw_hi  = (side_r[S_MUL].region == jlvbs_pkg::REGION_UPPER) ?
              bnd_r : $signed(side_r[S_MUL].vmax);
    vprev_s = $signed(side_r[S_MUL].vprev);
    lo_ext  = (VW+1)'(raw_lo);
    hi_ext  = (VW+1)'(raw_hi);
    abs_lo  = (lo_ext < 0) ? -lo_ext : lo_ext;
    abs_hi  = (hi_ext < 0) ? -hi_ext : hi_ext;
    if (raw_lo < raw_hi) begin
      xl = raw_lo;
      xu = raw_hi;
    end else if (raw_hi < 0 && raw_lo > 0) begin
      xl = '0;
      xu = '0;
    end else if (abs_lo < abs_hi) begin
      xl = raw_lo;
      xu = raw_lo;
    end else begin
      xl = raw_hi;
      xu = raw_hi;
    end
    // clamp against the bounds before reconciliation
    sv_a = (vprev_s > raw_lo) ? vprev_s : raw_lo;
    sv   = (sv_a > raw_hi) ? raw_hi : sv_a;
  end

  always_ff @(posedge clk) begin
    if (adv[S_OUT]) begin
      tag_r    <= side_r[S_MUL].tag;
      vlo_r    <= xl;
      vhi_r    <= xu;
      sv_r     <= sv;
      region_r <= side_r[S_MUL].region;
    end
  end

  assign out_joint_tag = tag_r;
  assign out_vel_low   = vlo_r;
  assign out_vel_high  = vhi_r;
  assign out_start_vel = sv_r;
  assign out_region    = region_r;

`ifndef SYNTHESIS
  a_bounds_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_vel_low <= out_vel_high))
    else $error("reconciled low bound above high bound");

  a_entry_from_input: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[S_IN] && !$past(vld_r[S_IN])) |-> $past(in_valid && in_ready))
    else $error("first stage filled without an accepted beat");

  a_div_rem_below_range: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[S_ROM-1] && side_r[S_ROM-1].band) |-> (div_rem_r[QB] < div_rng_r[QB]))
    else $error("divider remainder not below divisor");
`endif

endmodule
